### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the checker file of this block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define CGER_ASSERT(lbl, ck, rstn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
    else $error("cger assertion failed");

// clocked assertion that is also checked during reset
`define CGER_ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("cger assertion failed");

`endif

### rtl/cger_pkg.sv
// ----------------------------------------------------------------------------
// cger_pkg
// types and constants of the camera gain and exposure regulator
// ----------------------------------------------------------------------------
`default_nettype none

package cger_pkg;

  // rail proximity margin in raw Q8.8 units
  localparam int RAIL_MARGIN = 1;

  // divider layout: quotient bits and radix-2 steps per pipeline stage
  localparam int QBITS      = 18;
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = QBITS / DIV_STEPS;

  // accept edge to the edge that takes the result
  localparam int LATENCY = DIV_STAGES + 6;

  // configuration port widths
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEVEL     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAIL_LOW         = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAIL_HIGH        = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FLOOR       = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CEILING     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EXPOSURE_FLOOR   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EXPOSURE_CEILING = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_FACTOR     = 4'd7;

  // register reset values
  localparam logic [15:0] RST_TARGET_LEVEL     = 16'd32768;
  localparam logic [15:0] RST_RAIL_LOW         = 16'd0;
  localparam logic [15:0] RST_RAIL_HIGH        = 16'd65280;
  localparam logic [15:0] RST_GAIN_FLOOR       = 16'd256;
  localparam logic [15:0] RST_GAIN_CEILING     = 16'd2720;
  localparam logic [19:0] RST_EXPOSURE_FLOOR   = 20'd37;
  localparam logic [19:0] RST_EXPOSURE_CEILING = 20'd4839;
  localparam logic [16:0] RST_SPEED_FACTOR     = 17'd62259;

  // fixed-point constants
  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [17:0] ONE_Q16_W   = 18'd65536;
  localparam logic [17:0] QUARTER_Q16 = 18'd16384;
  localparam logic [17:0] DEV_POS_MAX = 18'd131071;
  localparam logic [17:0] DEV_NEG_MAX = 18'd131072;

  // action codes
  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_EXP_UP    = 3'd1;
  localparam logic [2:0] ACT_GAIN_UP   = 3'd2;
  localparam logic [2:0] ACT_GAIN_DOWN = 3'd3;
  localparam logic [2:0] ACT_EXP_DOWN  = 3'd4;

  typedef struct packed {
    logic [15:0] signal_level;
    logic [15:0] gain_now;
    logic [19:0] exposure_now;
  } cger_in_t;

  typedef struct packed {
    logic [15:0] gain_next;
    logic [19:0] exposure_next;
    logic [2:0]  action_taken;
  } cger_out_t;

endpackage

`default_nettype wire

### rtl/camera_gain_exposure_regulator.sv
// ----------------------------------------------------------------------------
// camera_gain_exposure_regulator
// auto exposure and gain step: deviation divider, damping, scale and clamp
// ----------------------------------------------------------------------------
// pipeline: an accepted request passes the divider stages, then the saturation,
//   damping, decision, scale and result registers, which raise its result strobe
// throughput: one request per cycle, set by the pipelined radix-2 divider
// reset: synchronous, active low; clears valid bits and loads register defaults
// busy is high only while reset is held; the result side never stalls
`default_nettype none

module camera_gain_exposure_regulator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire cger_pkg::cger_in_t              in_req,
  output logic                                 out_strobe,
  output cger_pkg::cger_out_t                  out_result,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [cger_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cger_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int QB = cger_pkg::QBITS;
  localparam int NS = cger_pkg::DIV_STAGES;
  localparam int ST = cger_pkg::DIV_STEPS;

  // divider pipeline word
  typedef struct packed {
    logic          vld;
    logic          neg;
    logic          ovf;
    logic          rail;
    logic [15:0]   gain;
    logic [19:0]   expo;
    logic [1:0]    dlo;
    logic [15:0]   rem;
    logic [QB-1:0] q;
  } div_t;

  typedef struct packed {
    logic        vld;
    logic        neg;
    logic [17:0] mag;
    logic [16:0] onems;
    logic [15:0] gain;
    logic [19:0] expo;
  } sat_t;

  typedef struct packed {
    logic        vld;
    logic        neg;
    logic [17:0] dmag;
    logic [15:0] gain;
    logic [19:0] expo;
  } dmp_t;

  typedef struct packed {
    logic        vld;
    logic [2:0]  act;
    logic        cpos;
    logic [17:0] cmag;
    logic [19:0] opnd;
    logic [15:0] gain;
    logic [19:0] expo;
  } dec_t;

  typedef struct packed {
    logic        vld;
    logic [2:0]  act;
    logic [21:0] scaled;
    logic [15:0] gain;
    logic [19:0] expo;
  } mul_t;

  // configuration registers
  logic [15:0] target_r, rail_lo_r, rail_hi_r, gfloor_r, gceil_r;
  logic [19:0] efloor_r, eceil_r;
  logic [16:0] speed_r;
  logic [16:0] sp_r, sp2_r, sp3_r;
  logic [15:0] t_eff;

  logic accept;

  div_t div_r [0:NS];
  div_t div_nxt;
  sat_t sat_r, sat_nxt;
  dmp_t dmp_r, dmp_nxt;
  dec_t dec_r, dec_nxt;
  mul_t mul_r, mul_nxt;
  cger_pkg::cger_out_t out_r, out_nxt;
  logic strobe_r;

  assign busy      = ~rst_n;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;
  assign t_eff     = (target_r == 16'd0) ? 16'd1 : target_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r  <= cger_pkg::RST_TARGET_LEVEL;
      rail_lo_r <= cger_pkg::RST_RAIL_LOW;
      rail_hi_r <= cger_pkg::RST_RAIL_HIGH;
      gfloor_r  <= cger_pkg::RST_GAIN_FLOOR;
      gceil_r   <= cger_pkg::RST_GAIN_CEILING;
      efloor_r  <= cger_pkg::RST_EXPOSURE_FLOOR;
      eceil_r   <= cger_pkg::RST_EXPOSURE_CEILING;
      speed_r   <= cger_pkg::RST_SPEED_FACTOR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cger_pkg::REG_TARGET_LEVEL:     target_r  <= cfg_data[15:0];
        cger_pkg::REG_RAIL_LOW:         rail_lo_r <= cfg_data[15:0];
        cger_pkg::REG_RAIL_HIGH:        rail_hi_r <= cfg_data[15:0];
        cger_pkg::REG_GAIN_FLOOR:       gfloor_r  <= cfg_data[15:0];
        cger_pkg::REG_GAIN_CEILING:     gceil_r   <= cfg_data[15:0];
        cger_pkg::REG_EXPOSURE_FLOOR:   efloor_r  <= cfg_data[19:0];
        cger_pkg::REG_EXPOSURE_CEILING: eceil_r   <= cfg_data[19:0];
        cger_pkg::REG_SPEED_FACTOR:     speed_r   <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // speed powers: speed clamped to one, then its square and cube, one multiply each
  logic [33:0] sq_prod, cube_prod;
  assign sq_prod   = 34'(sp_r) * 34'(sp_r);
  assign cube_prod = 34'(sp2_r) * 34'(sp_r);

  always_ff @(posedge clk) begin
    sp_r  <= (speed_r > cger_pkg::ONE_Q16) ? cger_pkg::ONE_Q16 : speed_r;
    sp2_r <= sq_prod[32:16];
    sp3_r <= cube_prod[32:16];
  end

  // entry stage: deviation magnitude, sign, overflow and rail proximity
  always_comb begin
    logic [15:0] s, d, dlo_diff, dhi_diff;
    s = in_req.signal_level;
    div_nxt.vld  = accept;
    div_nxt.neg  = s > t_eff;
    d            = div_nxt.neg ? (s - t_eff) : (t_eff - s);
    div_nxt.ovf  = {2'b00, d} >= {t_eff, 2'b00};
    dlo_diff     = (s >= rail_lo_r) ? (s - rail_lo_r) : (rail_lo_r - s);
    dhi_diff     = (s >= rail_hi_r) ? (s - rail_hi_r) : (rail_hi_r - s);
    div_nxt.rail = ({1'b0, dlo_diff} <= 17'(cger_pkg::RAIL_MARGIN)) ||
                   ({1'b0, dhi_diff} <= 17'(cger_pkg::RAIL_MARGIN));
    div_nxt.gain = in_req.gain_now;
    div_nxt.expo = in_req.exposure_now;
    div_nxt.dlo  = d[1:0];
    div_nxt.rem  = {2'b00, d[15:2]};
    div_nxt.q    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r[0].vld <= 1'b0;
    end else begin
      div_r[0] <= div_nxt;
    end
  end

  // restoring divider, DIV_STEPS quotient bits per stage
  for (genvar i = 0; i < NS; i++) begin : g_div
    div_t stage_nxt;

    always_comb begin
      logic [16:0] trial;
      logic        shift_in;
      stage_nxt = div_r[i];
      for (int k = 0; k < ST; k++) begin
        if ((i * ST + k) == 0) begin
          shift_in = div_r[i].dlo[1];
        end else if ((i * ST + k) == 1) begin
          shift_in = div_r[i].dlo[0];
        end else begin
          shift_in = 1'b0;
        end
        trial = {stage_nxt.rem, shift_in};
        if (trial >= {1'b0, t_eff}) begin
          stage_nxt.rem = 16'(trial - {1'b0, t_eff});
          stage_nxt.q   = {stage_nxt.q[QB-2:0], 1'b1};
        end else begin
          stage_nxt.rem = trial[15:0];
          stage_nxt.q   = {stage_nxt.q[QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_r[i+1].vld <= 1'b0;
      end else begin
        div_r[i+1] <= stage_nxt;
      end
    end
  end

  // saturate deviation and pick the speed
  always_comb begin
    div_t        dv;
    logic [16:0] speed;
    dv = div_r[NS];
    sat_nxt.vld  = dv.vld;
    sat_nxt.neg  = dv.neg;
    sat_nxt.gain = dv.gain;
    sat_nxt.expo = dv.expo;
    if (dv.neg) begin
      sat_nxt.mag = (dv.ovf || dv.q > cger_pkg::DEV_NEG_MAX) ? cger_pkg::DEV_NEG_MAX : dv.q;
    end else begin
      sat_nxt.mag = (dv.ovf || dv.q > cger_pkg::DEV_POS_MAX) ? cger_pkg::DEV_POS_MAX : dv.q;
    end
    if (sat_nxt.mag < cger_pkg::QUARTER_Q16) begin
      speed = sp2_r;
    end else if (dv.rail) begin
      speed = sp3_r;
    end else begin
      speed = sp_r;
    end
    sat_nxt.onems = cger_pkg::ONE_Q16 - speed;
  end

  // damping multiply
  logic [34:0] damp_prod;
  assign damp_prod = 35'(sat_r.mag) * 35'(sat_r.onems);

  always_comb begin
    dmp_nxt.vld  = sat_r.vld;
    dmp_nxt.neg  = sat_r.neg;
    dmp_nxt.dmag = damp_prod[33:16];
    dmp_nxt.gain = sat_r.gain;
    dmp_nxt.expo = sat_r.expo;
  end

  // decide action and correction factor
  always_comb begin
    dec_nxt.vld  = dmp_r.vld;
    dec_nxt.gain = dmp_r.gain;
    dec_nxt.expo = dmp_r.expo;
    dec_nxt.act  = cger_pkg::ACT_NONE;
    dec_nxt.cpos = 1'b0;
    dec_nxt.cmag = '0;
    dec_nxt.opnd = dmp_r.expo;
    if (dmp_r.dmag != 18'd0) begin
      if (!dmp_r.neg) begin
        dec_nxt.cpos = 1'b1;
        dec_nxt.cmag = cger_pkg::ONE_Q16_W + dmp_r.dmag;
        if (dmp_r.expo < eceil_r) begin
          dec_nxt.act  = cger_pkg::ACT_EXP_UP;
          dec_nxt.opnd = dmp_r.expo;
        end else begin
          dec_nxt.act  = cger_pkg::ACT_GAIN_UP;
          dec_nxt.opnd = {4'b0000, dmp_r.gain};
        end
      end else begin
        dec_nxt.cpos = dmp_r.dmag < cger_pkg::ONE_Q16_W;
        dec_nxt.cmag = cger_pkg::ONE_Q16_W - dmp_r.dmag;
        if (dmp_r.gain > gfloor_r) begin
          dec_nxt.act  = cger_pkg::ACT_GAIN_DOWN;
          dec_nxt.opnd = {4'b0000, dmp_r.gain};
        end else begin
          dec_nxt.act  = cger_pkg::ACT_EXP_DOWN;
          dec_nxt.opnd = dmp_r.expo;
        end
      end
    end
  end

  // scale multiply
  logic [37:0] scale_prod;
  assign scale_prod = 38'(dec_r.opnd) * 38'(dec_r.cmag);

  always_comb begin
    mul_nxt.vld    = dec_r.vld;
    mul_nxt.act    = dec_r.act;
    mul_nxt.gain   = dec_r.gain;
    mul_nxt.expo   = dec_r.expo;
    mul_nxt.scaled = dec_r.cpos ? scale_prod[37:16] : 22'd0;
  end

  // clamp, floor first then ceiling
  always_comb begin
    logic [21:0] lo, hi, r1, r2;
    if (mul_r.act == cger_pkg::ACT_EXP_UP || mul_r.act == cger_pkg::ACT_EXP_DOWN) begin
      lo = {2'b00, efloor_r};
      hi = {2'b00, eceil_r};
    end else begin
      lo = {6'd0, gfloor_r};
      hi = {6'd0, gceil_r};
    end
    r1 = (mul_r.scaled < lo) ? lo : mul_r.scaled;
    r2 = (r1 > hi) ? hi : r1;
    out_nxt.gain_next     = mul_r.gain;
    out_nxt.exposure_next = mul_r.expo;
    out_nxt.action_taken  = mul_r.act;
    case (mul_r.act)
      cger_pkg::ACT_EXP_UP, cger_pkg::ACT_EXP_DOWN:   out_nxt.exposure_next = r2[19:0];
      cger_pkg::ACT_GAIN_UP, cger_pkg::ACT_GAIN_DOWN: out_nxt.gain_next     = r2[15:0];
      default: ;
    endcase
  end

  // back-end pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r.vld <= 1'b0;
      dmp_r.vld <= 1'b0;
      dec_r.vld <= 1'b0;
      mul_r.vld <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      sat_r    <= sat_nxt;
      dmp_r    <= dmp_nxt;
      dec_r    <= dec_nxt;
      mul_r    <= mul_nxt;
      strobe_r <= mul_r.vld;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_result = out_r;

endmodule

`default_nettype wire

### rtl/cger_checker.sv
// ----------------------------------------------------------------------------
// cger_checker
// port level checks of the regulator, attached to the top level by bind
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cger_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_strobe,
  input wire cger_pkg::cger_out_t out_result
);

  // pipeline is flushed by reset
  `CGER_ASSERT_ALWAYS(a_no_strobe_after_reset, clk, !rst_n |=> !out_strobe)

  // every result belongs to a request accepted a fixed time earlier
  `CGER_ASSERT(a_fixed_latency, clk, rst_n, out_strobe |-> $past(start && !busy, cger_pkg::LATENCY))

  // action code stays within its defined set
  `CGER_ASSERT(a_action_code, clk, rst_n, out_strobe |-> out_result.action_taken <= cger_pkg::ACT_EXP_DOWN)

  // requests are only refused during reset
  `CGER_ASSERT_ALWAYS(a_busy_only_in_reset, clk, rst_n |-> !busy)

endmodule

bind camera_gain_exposure_regulator cger_checker u_cger_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_result (out_result)
);

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// frame measurements driven into the gain and exposure regulator through the
// start/busy request port, register reprogramming between phases while the
// pipe is empty, every result checked field by field in acceptance order
// ----------------------------------------------------------------------------

module testbench;
  import cger_pkg::*;

  // register indexes the block has no register behind
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;
  localparam int                   SEG_ITEMS     = 50;
  localparam int                   SEG_COUNT     = 10;

  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    cger_in_t              req;
    bit                    typed;
    cger_out_t             want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  cger_in_t              in_req;
  logic                  out_strobe;
  cger_out_t             out_result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor copy of the register file
  logic [15:0] target_lvl  = RST_TARGET_LEVEL;
  logic [15:0] rail_lo     = RST_RAIL_LOW;
  logic [15:0] rail_hi     = RST_RAIL_HIGH;
  logic [15:0] gain_min    = RST_GAIN_FLOOR;
  logic [15:0] gain_max    = RST_GAIN_CEILING;
  logic [19:0] expo_min    = RST_EXPOSURE_FLOOR;
  logic [19:0] expo_max    = RST_EXPOSURE_CEILING;
  logic [16:0] damp_speed  = RST_SPEED_FACTOR;

  cger_out_t   pending_adjust[$];
  stim_row_t   stim_rows[$];
  bit          typed_on;
  cger_out_t   typed_want;
  int          mismatch_count;

  camera_gain_exposure_regulator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_result (out_result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 100 MHz clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // runaway guard
  initial begin
    #(2_000_000);
    $display("status: fail");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch: %s", msg);
  endtask

  function automatic void set_register(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_TARGET_LEVEL:     target_lvl = data[15:0];
      REG_RAIL_LOW:         rail_lo    = data[15:0];
      REG_RAIL_HIGH:        rail_hi    = data[15:0];
      REG_GAIN_FLOOR:       gain_min   = data[15:0];
      REG_GAIN_CEILING:     gain_max   = data[15:0];
      REG_EXPOSURE_FLOOR:   expo_min   = data[19:0];
      REG_EXPOSURE_CEILING: expo_max   = data[19:0];
      REG_SPEED_FACTOR:     damp_speed = data[16:0];
      default: ;
    endcase
  endfunction

  // scale by a Q2.16 correction, then floor first and ceiling last
  function automatic logic [19:0] rescale(input longint unsigned v, input longint c,
                                          input longint unsigned lo,
                                          input longint unsigned hi);
    longint unsigned r;
    r = '0;
    if (c > 0) r = (v * unsigned'(c)) >> 16;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r[19:0];
  endfunction

  function automatic cger_out_t predict_adjust(input cger_in_t req);
    longint unsigned sig, tgt, sp, sp2, sp3, spd, diff, mag, dmag, near_lo, near_hi;
    longint          dd, corr;
    bit              neg;
    cger_out_t       res;
    sig  = 64'(req.signal_level);
    tgt  = (target_lvl == 16'd0) ? 64'd1 : 64'(target_lvl);
    sp   = (damp_speed > ONE_Q16) ? 64'(ONE_Q16) : 64'(damp_speed);
    sp2  = (sp * sp) >> 16;
    sp3  = (sp2 * sp) >> 16;
    neg  = sig > tgt;
    diff = neg ? sig - tgt : tgt - sig;
    mag  = (diff << 16) / tgt;
    if (neg && mag > 64'(DEV_NEG_MAX)) mag = 64'(DEV_NEG_MAX);
    if (!neg && mag > 64'(DEV_POS_MAX)) mag = 64'(DEV_POS_MAX);
    // rail proximity switches to speed cubed, a small deviation to speed squared
    near_lo = (sig >= 64'(rail_lo)) ? sig - 64'(rail_lo) : 64'(rail_lo) - sig;
    near_hi = (sig >= 64'(rail_hi)) ? sig - 64'(rail_hi) : 64'(rail_hi) - sig;
    spd = sp;
    if (near_lo <= 64'(RAIL_MARGIN) || near_hi <= 64'(RAIL_MARGIN)) spd = sp3;
    if (mag < 64'(QUARTER_Q16)) spd = sp2;
    dmag = (mag * (64'(ONE_Q16) - spd)) >> 16;
    dd   = neg ? -longint'(dmag) : longint'(dmag);
    res.gain_next     = req.gain_now;
    res.exposure_next = req.exposure_now;
    res.action_taken  = ACT_NONE;
    if (dd != 0) begin
      corr = longint'(ONE_Q16) + dd;
      if (dd > 0) begin
        if (req.exposure_now < expo_max) begin
          res.exposure_next = rescale(64'(req.exposure_now), corr,
                                      64'(expo_min), 64'(expo_max));
          res.action_taken  = ACT_EXP_UP;
        end else begin
          res.gain_next    = 16'(rescale(64'(req.gain_now), corr,
                                         64'(gain_min), 64'(gain_max)));
          res.action_taken = ACT_GAIN_UP;
        end
      end else begin
        if (req.gain_now > gain_min) begin
          res.gain_next    = 16'(rescale(64'(req.gain_now), corr,
                                         64'(gain_min), 64'(gain_max)));
          res.action_taken = ACT_GAIN_DOWN;
        end else begin
          res.exposure_next = rescale(64'(req.exposure_now), corr,
                                      64'(expo_min), 64'(expo_max));
          res.action_taken  = ACT_EXP_DOWN;
        end
      end
    end
    return res;
  endfunction

  // result check, request capture and register mirror at each edge
  always @(posedge clk) begin : result_check
    cger_out_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (pending_adjust.size() == 0) begin
          flag_mismatch("result strobe with no request outstanding");
        end else begin
          want = pending_adjust.pop_front();
          if (out_result.gain_next !== want.gain_next)
            flag_mismatch($sformatf("gain_next got %0d want %0d",
                                    out_result.gain_next, want.gain_next));
          if (out_result.exposure_next !== want.exposure_next)
            flag_mismatch($sformatf("exposure_next got %0d want %0d",
                                    out_result.exposure_next, want.exposure_next));
          if (out_result.action_taken !== want.action_taken)
            flag_mismatch($sformatf("action_taken got %0d want %0d",
                                    out_result.action_taken, want.action_taken));
        end
      end
      if (start && !busy)
        pending_adjust.push_back(typed_on ? typed_want : predict_adjust(in_req));
      if (cfg_valid && cfg_ready) set_register(cfg_index, cfg_data);
    end
  end

  function automatic void add_item(input logic [15:0] sig, input logic [15:0] gain,
                                   input logic [19:0] expo, input bit typed,
                                   input cger_out_t want);
    stim_row_t row;
    row          = '{default: '0};
    row.req      = '{sig, gain, expo};
    row.typed    = typed;
    row.want     = want;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row          = '{default: '0};
    row.is_write = 1'b1;
    row.idx      = idx;
    row.data     = data;
    stim_rows.push_back(row);
  endfunction

  function automatic int bound(input int v, input int top);
    if (v < 0) return 0;
    if (v > top) return top;
    return v;
  endfunction

  // present one request, with random idle cycles ahead of it
  task automatic push_request(input cger_in_t req, input bit may_idle,
                              input bit typed, input cger_out_t want);
    while (may_idle && $urandom_range(0, 99) < 23) begin
      start  = 1'b0;
      in_req = '{16'($urandom), 16'($urandom), 20'($urandom)};
      @(negedge clk);
    end
    start      = 1'b1;
    in_req     = req;
    typed_on   = typed;
    typed_want = want;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  // stop issuing and let every outstanding request come back
  task automatic drain_pipe();
    start = 1'b0;
    while (pending_adjust.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
  endtask

  initial begin
    int          seg, n, guard, v, lo_v, hi_v, swap_v, sig_v, gain_v, expo_v;
    logic [16:0] speed_v;
    start          = 1'b0;
    in_req         = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    typed_on       = 1'b0;
    typed_want     = '0;
    mismatch_count = 0;
    rst_n          = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed rows, reset settings first
    add_item(16'd32768, 16'd1000, 20'd1000, 1'b1, cger_out_t'{16'd1000, 20'd1000, ACT_NONE});
    add_item(16'd0, 16'd0, 20'd0, 1'b0, '0);
    add_item(16'hFFFF, 16'hFFFF, 20'hFFFFF, 1'b0, '0);
    add_item(16'd65280, 16'd2000, 20'd5000, 1'b0, '0);
    add_item(16'd65281, 16'd256, 20'd100, 1'b0, '0);
    add_item(16'd1, 16'd300, 20'd4839, 1'b0, '0);
    add_item(16'd16384, 16'd500, 20'd200, 1'b0, '0);
    add_item(16'd40000, 16'd800, 20'd3000, 1'b0, '0);
    add_item(16'd30000, 16'd1000, 20'd1000, 1'b0, '0);
    add_item(16'd32767, 16'd1000, 20'd1000, 1'b0, '0);
    // full damping freezes everything, also when the speed is above one
    add_write(REG_SPEED_FACTOR, 20'd65536);
    add_item(16'd0, 16'd1234, 20'd567, 1'b1, cger_out_t'{16'd1234, 20'd567, ACT_NONE});
    add_write(REG_SPEED_FACTOR, 20'd131071);
    add_item(16'hFFFF, 16'd4000, 20'd99, 1'b1, cger_out_t'{16'd4000, 20'd99, ACT_NONE});
    // no damping, zero target counts as one
    add_write(REG_SPEED_FACTOR, 20'd0);
    add_write(REG_TARGET_LEVEL, 20'd0);
    add_item(16'd0, 16'd500, 20'd500, 1'b0, '0);
    add_item(16'd1, 16'd700, 20'd800, 1'b1, cger_out_t'{16'd700, 20'd800, ACT_NONE});
    add_item(16'hFFFF, 16'd3000, 20'd800, 1'b0, '0);
    // correction of exactly zero
    add_write(REG_TARGET_LEVEL, 20'd1000);
    add_item(16'd2000, 16'd1000, 20'd700, 1'b0, '0);
    // floors above ceilings
    add_write(REG_GAIN_FLOOR, 20'd3000);
    add_write(REG_GAIN_CEILING, 20'd1000);
    add_write(REG_EXPOSURE_FLOOR, 20'd5000);
    add_write(REG_EXPOSURE_CEILING, 20'd2000);
    add_item(16'd1500, 16'd5000, 20'd300, 1'b0, '0);
    add_item(16'd500, 16'd100, 20'd10, 1'b0, '0);
    // writes to indexes with no register behind them change nothing
    add_write(REG_UNUSED_LO, 20'hFFFFF);
    add_write(REG_UNUSED_HI, 20'd0);
    add_item(16'd500, 16'd100, 20'd10, 1'b0, '0);
    // back to power-up settings
    add_write(REG_TARGET_LEVEL, CFG_DATA_W'(RST_TARGET_LEVEL));
    add_write(REG_RAIL_LOW, CFG_DATA_W'(RST_RAIL_LOW));
    add_write(REG_RAIL_HIGH, CFG_DATA_W'(RST_RAIL_HIGH));
    add_write(REG_GAIN_FLOOR, CFG_DATA_W'(RST_GAIN_FLOOR));
    add_write(REG_GAIN_CEILING, CFG_DATA_W'(RST_GAIN_CEILING));
    add_write(REG_EXPOSURE_FLOOR, RST_EXPOSURE_FLOOR);
    add_write(REG_EXPOSURE_CEILING, RST_EXPOSURE_CEILING);
    add_write(REG_SPEED_FACTOR, CFG_DATA_W'(RST_SPEED_FACTOR));
    add_item(16'd20000, 16'd1500, 20'd1500, 1'b0, '0);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_write) begin
        drain_pipe();
        write_reg(stim_rows[i].idx, stim_rows[i].data);
      end else begin
        cfg_valid = 1'b0;
        push_request(stim_rows[i].req, 1'b1, stim_rows[i].typed, stim_rows[i].want);
      end
    end

    // random segments, each under fresh settings
    for (seg = 0; seg < SEG_COUNT; seg++) begin
      drain_pipe();
      case ($urandom_range(0, 4))
        0:       v = 0;
        1:       v = 1;
        2:       v = 65535;
        default: v = $urandom_range(1, 65535);
      endcase
      write_reg(REG_TARGET_LEVEL, CFG_DATA_W'(v));
      write_reg(REG_RAIL_LOW,
                CFG_DATA_W'(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 65535)));
      write_reg(REG_RAIL_HIGH,
                CFG_DATA_W'(($urandom_range(0, 2) == 0) ? 65535 : $urandom_range(0, 65535)));
      // gain range, usually ordered, now and then inverted or at an extreme
      lo_v = $urandom_range(0, 65535);
      hi_v = $urandom_range(0, 65535);
      if (lo_v > hi_v) begin
        swap_v = lo_v;
        lo_v   = hi_v;
        hi_v   = swap_v;
      end
      if ($urandom_range(0, 5) == 0) lo_v = 0;
      if ($urandom_range(0, 5) == 0) hi_v = 65535;
      if ($urandom_range(0, 5) == 0) begin
        swap_v = lo_v;
        lo_v   = hi_v;
        hi_v   = swap_v;
      end
      write_reg(REG_GAIN_FLOOR, CFG_DATA_W'(lo_v));
      write_reg(REG_GAIN_CEILING, CFG_DATA_W'(hi_v));
      // exposure range, same shape
      lo_v = $urandom_range(0, 1048575);
      hi_v = $urandom_range(0, 1048575);
      if (lo_v > hi_v) begin
        swap_v = lo_v;
        lo_v   = hi_v;
        hi_v   = swap_v;
      end
      if ($urandom_range(0, 5) == 0) lo_v = 0;
      if ($urandom_range(0, 5) == 0) hi_v = 1048575;
      if ($urandom_range(0, 5) == 0) begin
        swap_v = lo_v;
        lo_v   = hi_v;
        hi_v   = swap_v;
      end
      write_reg(REG_EXPOSURE_FLOOR, CFG_DATA_W'(lo_v));
      write_reg(REG_EXPOSURE_CEILING, CFG_DATA_W'(hi_v));
      case ($urandom_range(0, 7))
        0:       speed_v = 17'd0;
        1:       speed_v = ONE_Q16;
        2:       speed_v = 17'($urandom_range(65537, 131071));
        3, 4:    speed_v = 17'($urandom_range(55000, 65535));
        default: speed_v = 17'($urandom_range(0, 65535));
      endcase
      write_reg(REG_SPEED_FACTOR, CFG_DATA_W'(speed_v));
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                  CFG_DATA_W'($urandom_range(0, 1048575)));
      cfg_valid = 1'b0;

      for (n = 0; n < SEG_ITEMS; n++) begin
        // signal around the target, on a rail, at an extreme or anywhere
        case ($urandom_range(0, 5))
          0:       sig_v = int'(target_lvl) + int'($urandom_range(0, 600)) - 300;
          1:       sig_v = int'(rail_lo) + int'($urandom_range(0, 4)) - 2;
          2:       sig_v = int'(rail_hi) + int'($urandom_range(0, 4)) - 2;
          3:       sig_v = $urandom_range(0, 1) ? 65535 : 0;
          default: sig_v = $urandom_range(0, 65535);
        endcase
        case ($urandom_range(0, 3))
          0:       gain_v = int'(gain_min) + int'($urandom_range(0, 2)) - 1;
          1:       gain_v = int'(gain_max) + int'($urandom_range(0, 2)) - 1;
          default: gain_v = $urandom_range(0, 65535);
        endcase
        case ($urandom_range(0, 3))
          0:       expo_v = int'(expo_min) + int'($urandom_range(0, 2)) - 1;
          1:       expo_v = int'(expo_max) + int'($urandom_range(0, 2)) - 1;
          default: expo_v = $urandom_range(0, 1048575);
        endcase
        // two segments run back to back with no idle cycles
        push_request('{16'(bound(sig_v, 65535)), 16'(bound(gain_v, 65535)),
                       20'(bound(expo_v, 1048575))},
                     !(seg == 4 || seg == 5), 1'b0, '0);
      end
    end

    // wind down and give the last requests time to come back
    start = 1'b0;
    guard = 0;
    while (pending_adjust.size() != 0 && guard < 20 * LATENCY) begin
      @(negedge clk);
      guard++;
    end
    repeat (LATENCY + 4) @(negedge clk);
    if (pending_adjust.size() != 0)
      flag_mismatch($sformatf("%0d requests never produced a result",
                              pending_adjust.size()));

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/cger_pkg.sv
rtl/camera_gain_exposure_regulator.sv
rtl/cger_checker.sv
verif/testbench.sv
